// File: src/bre_pkg.sv
`timescale 1ns / 1ps

package bre_pkg;

	// widths fixed by the stream format
	localparam int BYTE_W          = 8;
	localparam int LEN_W           = 7;
	localparam int WORD_BYTES      = 8;
	localparam int WORD_W          = BYTE_W * WORD_BYTES;
	localparam int CNT_W           = 4;
	localparam int PCNT_W          = 3;
	localparam int M_TDATA_W       = 72;

	// largest segment the format can carry, and the default cap
	localparam int MAX_SEGMENT_DEF = 127;

	// literal buffer pointers carry one wrap bit above the largest address
	localparam int PTR_W           = 9;

	localparam int FIFO_DEPTH      = 4;

	localparam logic [BYTE_W-1:0] LIT_FLAG = 8'h80;

	// one closed segment handed from front to back
	typedef struct packed {
		logic                run;
		logic                flush;
		logic [LEN_W-1:0]    len;
		logic [BYTE_W-1:0]   run_byte;
		logic [PTR_W-1:0]    start;
	} cmd_t;

	typedef struct packed {
		logic                en;
		logic [PTR_W-1:0]    addr;
		logic [BYTE_W-1:0]   data;
	} lit_wr_t;

	typedef struct packed {
		logic                en;
		logic [PTR_W-1:0]    addr;
	} lit_rd_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_HEAD,
		B_RUNB,
		B_LIT
	} back_state_t;

endpackage

// File: src/bre_lit_ram.sv
`timescale 1ns / 1ps

module bre_lit_ram #(
	parameter int ADDR_W = 8
) (
	input  logic                          clk,
	input  bre_pkg::lit_wr_t              wr,
	input  bre_pkg::lit_rd_t              rd,
	output logic [bre_pkg::BYTE_W-1:0]    rd_data
);
	import bre_pkg::*;

	localparam int DEPTH = 2 ** ADDR_W;

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[ADDR_W-1:0]] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr[ADDR_W-1:0]];
		end
	end

endmodule

// File: src/bre_cmd_fifo.sv
`timescale 1ns / 1ps

module bre_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bre_pkg::cmd_t push_data,
	input  logic          pop,
	output bre_pkg::cmd_t head,
	output logic          full,
	output logic          empty
);
	import bre_pkg::*;

	localparam int IDX_W = $clog2(FIFO_DEPTH);
	localparam int CNT_FW = $clog2(FIFO_DEPTH + 1);

	cmd_t              slot_q [FIFO_DEPTH];
	logic [IDX_W-1:0]  wptr_q;
	logic [IDX_W-1:0]  rptr_q;
	logic [CNT_FW-1:0] count_q;

	assign head  = slot_q[rptr_q];
	assign full  = (count_q == CNT_FW'(FIFO_DEPTH));
	assign empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + IDX_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + IDX_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_FW'(1);
				2'b01:   count_q <= count_q - CNT_FW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/bre_front.sv
`timescale 1ns / 1ps

module bre_front #(
	parameter int MAX_SEGMENT = bre_pkg::MAX_SEGMENT_DEF,
	parameter int ADDR_W      = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [bre_pkg::BYTE_W-1:0]  in_byte,
	input  logic                        in_last,
	output logic                        cmd_push,
	output bre_pkg::cmd_t               cmd_data,
	input  logic                        cmd_full,
	output bre_pkg::lit_wr_t            lit_wr,
	input  logic [bre_pkg::PTR_W-1:0]   free_ptr
);
	import bre_pkg::*;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SEGMENT);
	localparam logic [PTR_W-1:0] DEPTH   = PTR_W'(2 ** ADDR_W);

	logic [LEN_W-1:0]  seg_q;
	logic              run_q;
	logic [BYTE_W-1:0] prev_q;
	logic              have_q;
	logic [PTR_W-1:0]  start_q;
	logic [PTR_W-1:0]  wp_q;
	logic              pend_v_q;
	cmd_t              pend_q;

	logic              acc;
	logic              buf_full;
	logic              begin_run;
	logic              close_seg;
	logic              a_valid;
	cmd_t              cmd_a;
	cmd_t              cmd_b;
	logic [PTR_W-1:0]  wp_a;
	logic [LEN_W-1:0]  seg_b;
	logic              run_b;
	logic [PTR_W-1:0]  start_b;
	logic [PTR_W-1:0]  wp_b;
	logic [LEN_W-1:0]  seg_c;
	logic              pend_set;

	// literal buffer holds the open literal and every queued one
	assign buf_full = ((wp_q - free_ptr) == DEPTH);
	assign s_tready = !pend_v_q && !cmd_full && !buf_full;
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		begin_run = have_q && !run_q && (prev_q == in_byte);
		close_seg = have_q && !begin_run
			&& ((run_q && (prev_q != in_byte)) || (seg_q >= MAX_LEN));
		a_valid   = (begin_run && (seg_q > LEN_W'(1))) || close_seg;

		// literal cut short by a run start drops its last byte
		cmd_a.run      = begin_run ? 1'b0 : run_q;
		cmd_a.flush    = !in_last;
		cmd_a.len      = begin_run ? (seg_q - LEN_W'(1)) : seg_q;
		cmd_a.run_byte = prev_q;
		cmd_a.start    = start_q;

		// the dropped byte was the last one written, so give its slot back
		wp_a = begin_run ? (wp_q - PTR_W'(1)) : wp_q;

		if (!have_q || close_seg) begin
			seg_b = '0;
			run_b = 1'b0;
		end else if (begin_run) begin
			seg_b = LEN_W'(1);
			run_b = 1'b1;
		end else begin
			seg_b = seg_q;
			run_b = run_q;
		end

		start_b = (seg_b == '0) ? wp_a : start_q;
		wp_b    = run_b ? wp_a : (wp_a + PTR_W'(1));
		seg_c   = seg_b + LEN_W'(1);

		cmd_b.run      = run_b;
		cmd_b.flush    = 1'b1;
		cmd_b.len      = seg_c;
		cmd_b.run_byte = in_byte;
		cmd_b.start    = start_b;
	end

	always_comb begin
		lit_wr.en   = acc && !run_b;
		lit_wr.addr = wp_a;
		lit_wr.data = in_byte;
	end

	// a byte may close two segments: the second waits in pend until the queue has room
	always_comb begin
		cmd_push = 1'b0;
		cmd_data = cmd_b;
		pend_set = 1'b0;
		if (pend_v_q) begin
			cmd_push = !cmd_full;
			cmd_data = pend_q;
		end else if (acc) begin
			cmd_push = a_valid || in_last;
			cmd_data = a_valid ? cmd_a : cmd_b;
			pend_set = a_valid && in_last;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pend_q <= cmd_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q    <= '0;
			run_q    <= 1'b0;
			prev_q   <= '0;
			have_q   <= 1'b0;
			start_q  <= '0;
			wp_q     <= '0;
			pend_v_q <= 1'b0;
		end else begin
			pend_v_q <= pend_v_q ? cmd_full : pend_set;
			if (acc) begin
				seg_q   <= in_last ? '0 : seg_c;
				run_q   <= in_last ? 1'b0 : run_b;
				prev_q  <= in_byte;
				have_q  <= !in_last;
				start_q <= start_b;
				wp_q    <= wp_b;
			end
		end
	end

endmodule

// File: src/bre_back.sv
`timescale 1ns / 1ps

module bre_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_empty,
	input  bre_pkg::cmd_t               cmd_head,
	output logic                        cmd_pop,
	output bre_pkg::lit_rd_t            lit_rd,
	input  logic [bre_pkg::BYTE_W-1:0]  rd_data,
	output logic [bre_pkg::PTR_W-1:0]   free_ptr,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [bre_pkg::WORD_W-1:0]  out_bytes,
	output logic [bre_pkg::CNT_W-1:0]   out_count,
	output logic                        out_last
);
	import bre_pkg::*;

	back_state_t        state_q;
	back_state_t        state_d;
	cmd_t               cur_q;
	logic [LEN_W-1:0]   idx_q;
	logic [PTR_W-1:0]   fp_q;
	logic [WORD_W-1:0]  pack_q;
	logic [PCNT_W-1:0]  pcnt_q;
	logic               m_tvalid_q;
	logic [WORD_W-1:0]  out_bytes_q;
	logic [CNT_W-1:0]   out_count_q;
	logic               out_last_q;

	logic               last_idx;
	logic               seg_fin;
	logic               flush_now;
	logic               out_free;
	logic               word_full;
	logic               byte_ok;
	logic               byte_v;
	logic [BYTE_W-1:0]  byte_d;
	logic               taken;
	logic               load_out;
	logic [WORD_W-1:0]  word_new;

	assign last_idx  = (idx_q == (cur_q.len - LEN_W'(1)));
	assign seg_fin   = (state_q == B_RUNB) || ((state_q == B_LIT) && last_idx);
	assign flush_now = seg_fin && cur_q.flush;
	assign out_free  = !m_tvalid_q || m_tready;
	assign word_full = (pcnt_q == PCNT_W'(WORD_BYTES - 1));
	assign byte_ok   = out_free || (!flush_now && !word_full);

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!cmd_empty) begin
					state_d = B_HEAD;
				end
			end
			B_HEAD: begin
				if (byte_ok) begin
					state_d = cur_q.run ? B_RUNB : B_LIT;
				end
			end
			B_RUNB: begin
				if (byte_ok) begin
					state_d = B_IDLE;
				end
			end
			B_LIT: begin
				if (byte_ok && last_idx) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop     = 1'b0;
		byte_v      = 1'b0;
		byte_d      = cur_q.run_byte;
		lit_rd.en   = 1'b0;
		lit_rd.addr = cur_q.start;
		case (state_q)
			B_IDLE: begin
				cmd_pop = !cmd_empty;
			end
			B_HEAD: begin
				byte_v    = 1'b1;
				byte_d    = cur_q.run ? {1'b0, cur_q.len} : (LIT_FLAG | {1'b0, cur_q.len});
				lit_rd.en = !cur_q.run && byte_ok;
			end
			B_RUNB: begin
				byte_v = 1'b1;
			end
			B_LIT: begin
				byte_v      = 1'b1;
				byte_d      = rd_data;
				lit_rd.en   = byte_ok && !last_idx;
				lit_rd.addr = cur_q.start + PTR_W'(idx_q) + PTR_W'(1);
			end
			default: ;
		endcase
	end

	assign taken    = byte_v && byte_ok;
	assign load_out = taken && (word_full || flush_now);

	always_comb begin
		for (int k = 0; k < WORD_BYTES; k++) begin
			word_new[k*BYTE_W +: BYTE_W] = (pcnt_q == PCNT_W'(k)) ? byte_d
				: pack_q[k*BYTE_W +: BYTE_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd_head;
		end
		if (load_out) begin
			out_bytes_q <= word_new;
			out_count_q <= {1'b0, pcnt_q} + CNT_W'(1);
			out_last_q  <= flush_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			idx_q      <= '0;
			fp_q       <= '0;
			pack_q     <= '0;
			pcnt_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_HEAD) begin
				idx_q <= '0;
			end else if ((state_q == B_LIT) && byte_ok) begin
				idx_q <= idx_q + LEN_W'(1);
			end
			if ((state_q == B_LIT) && byte_ok && last_idx) begin
				fp_q <= cur_q.start + PTR_W'(cur_q.len);
			end
			if (load_out) begin
				pack_q <= '0;
				pcnt_q <= '0;
			end else if (taken) begin
				pack_q <= word_new;
				pcnt_q <= pcnt_q + PCNT_W'(1);
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign free_ptr  = fp_q;
	assign m_tvalid  = m_tvalid_q;
	assign out_bytes = out_bytes_q;
	assign out_count = out_count_q;
	assign out_last  = out_last_q;

endmodule

// File: src/byte_rle_encoder_unit.sv
// throughput: input takes one byte a cycle when not stalled; the back end fetches each
//   closed segment, then sends its header byte and then its run byte or literal bytes
// input stalls only when the segment queue or the literal buffer is full, or while a byte's
//   second closed segment waits; reset (arst_n low) empties everything, no clearing pass
`timescale 1ns / 1ps

module byte_rle_encoder_unit #(
	parameter int MAX_SEGMENT = bre_pkg::MAX_SEGMENT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input byte stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [bre_pkg::BYTE_W-1:0]     s_tdata,   // in_byte
	input  logic                           s_tlast,   // in_last
	// packed encoded words
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [bre_pkg::M_TDATA_W-1:0]  m_tdata,   // out_bytes[63:0], out_count[67:64], zero pad
	output logic                           m_tlast    // out_last
);
	import bre_pkg::*;

	// literal buffer is twice the segment cap, rounded to a power of two
	localparam int ADDR_W = $clog2(MAX_SEGMENT) + 1;

	// front to back segment queue
	logic               cmd_push;
	cmd_t               cmd_data;
	logic               cmd_full;
	logic               cmd_empty;
	logic               cmd_pop;
	cmd_t               cmd_head;

	// literal buffer ports
	lit_wr_t            lit_wr;
	lit_rd_t            lit_rd;
	logic [BYTE_W-1:0]  rd_data;
	logic [PTR_W-1:0]   free_ptr;

	logic [WORD_W-1:0]  out_bytes;
	logic [CNT_W-1:0]   out_count;

	// front end: run detection, literal capture, segment closing
	bre_front #(
		.MAX_SEGMENT (MAX_SEGMENT),
		.ADDR_W      (ADDR_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.cmd_push (cmd_push),
		.cmd_data (cmd_data),
		.cmd_full (cmd_full),
		.lit_wr   (lit_wr),
		.free_ptr (free_ptr)
	);

	// short queue of closed segments decouples the two sides
	bre_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_data),
		.pop       (cmd_pop),
		.head      (cmd_head),
		.full      (cmd_full),
		.empty     (cmd_empty)
	);

	// literal bytes wait here until their segment is sent
	bre_lit_ram #(
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr      (lit_wr),
		.rd      (lit_rd),
		.rd_data (rd_data)
	);

	// back end: header and body bytes, packed eight to a word
	bre_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_head  (cmd_head),
		.cmd_pop   (cmd_pop),
		.lit_rd    (lit_rd),
		.rd_data   (rd_data),
		.free_ptr  (free_ptr),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.out_bytes (out_bytes),
		.out_count (out_count),
		.out_last  (m_tlast)
	);

	assign m_tdata = {{(M_TDATA_W - WORD_W - CNT_W){1'b0}}, out_count, out_bytes};

endmodule

// File: tb/sv/tb_byte_rle_encoder_unit.sv
`timescale 1ns / 1ps

module tb_byte_rle_encoder_unit;

	import bre_pkg::*;

	localparam int CAP         = MAX_SEGMENT_DEF;
	localparam int IDLE_PCT    = 18;
	localparam int RAND_ITEMS  = 24;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 24;

	// one packed output word as the block should send it
	typedef struct packed {
		logic [WORD_W-1:0] data;
		logic [CNT_W-1:0]  cnt;
		logic              eos;
	} enc_word_t;

	// directed row: byte, end of stream, and an optional hand-typed word
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              eos;
		logic              typed;
		logic [WORD_W-1:0] word;
		logic [CNT_W-1:0]  cnt;
	} dir_row_t;

	localparam int N_ROWS = 20;
	localparam dir_row_t DIR_ROWS [N_ROWS] = '{
		// single byte streams at both extremes
		'{8'h00, 1'b1, 1'b1, 64'h0081, 4'd2},
		'{8'hFF, 1'b1, 1'b1, 64'hFF81, 4'd2},
		// shortest run of zeros
		'{8'h00, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'h00, 1'b1, 1'b1, 64'h0002, 4'd2},
		// run of three flushed at end of stream
		'{8'h55, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'h55, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'h55, 1'b1, 1'b1, 64'h5503, 4'd2},
		// literal cut short when a run begins
		'{8'h01, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'h02, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'h03, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'h03, 1'b1, 1'b0, 64'h0, 4'd0},
		// run closed by a different byte, then a literal of one
		'{8'hAA, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'hAA, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'h7F, 1'b1, 1'b0, 64'h0, 4'd0},
		// run straight after run: the literal between them is empty
		'{8'h10, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'h10, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'h20, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'h20, 1'b1, 1'b0, 64'h0, 4'd0},
		// literal holding the flag value itself
		'{8'h80, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'h01, 1'b1, 1'b0, 64'h0, 4'd0}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [BYTE_W-1:0]     s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tlast;

	// encoder shadow state
	logic [BYTE_W-1:0] lit_copy [0:CAP];
	int unsigned       seg_len;
	bit                run_mode;
	logic [BYTE_W-1:0] prev_byte;
	bit                have_prev;
	logic [BYTE_W-1:0] enc_bytes [$];
	enc_word_t         step_words [$];

	enc_word_t         expected_words [$];
	int                errors;
	bit                calm;
	int                idle_cycles;

	byte_rle_encoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// append one encoded byte to the shadow output
	function automatic void put_enc(logic [BYTE_W-1:0] v);
		enc_bytes.insert(enc_bytes.size(), v);
	endfunction

	function automatic void close_segment(int unsigned n, bit run);
		if (n == 0)
			return;
		if (run) begin
			put_enc(BYTE_W'(n & 'h7F));
			put_enc(prev_byte);
		end else begin
			put_enc(LIT_FLAG | BYTE_W'(n & 'h7F));
			for (int k = 0; k < n; k++)
				put_enc(lit_copy[k]);
		end
	endfunction

	// advance the shadow encoder by one byte and pack what it emits into words
	function automatic void encode_step(logic [BYTE_W-1:0] b, logic eos);
		enc_word_t   w;
		int unsigned n;
		int unsigned base;
		enc_bytes.delete();
		step_words.delete();
		if (have_prev) begin
			if (!run_mode && prev_byte == b) begin
				if (seg_len > 0)
					close_segment(seg_len - 1, 1'b0);
				seg_len  = 1;
				run_mode = 1'b1;
			end
			if ((run_mode && prev_byte != b) || seg_len >= CAP) begin
				close_segment(seg_len, run_mode);
				seg_len  = 0;
				run_mode = 1'b0;
			end
		end else begin
			seg_len  = 0;
			run_mode = 1'b0;
		end
		if (!run_mode)
			lit_copy[seg_len] = b;
		seg_len++;
		prev_byte = b;
		have_prev = 1'b1;
		if (eos) begin
			close_segment(seg_len, run_mode);
			seg_len   = 0;
			run_mode  = 1'b0;
			have_prev = 1'b0;
		end
		base = 0;
		while (base < enc_bytes.size()) begin
			n = enc_bytes.size() - base;
			if (n > WORD_BYTES)
				n = WORD_BYTES;
			w = '0;
			for (int k = 0; k < n; k++)
				w.data[BYTE_W*k +: BYTE_W] = enc_bytes[base + k];
			w.cnt = CNT_W'(n);
			base += n;
			w.eos = (base >= enc_bytes.size());
			step_words.insert(step_words.size(), w);
		end
	endfunction

	// offer one byte, wait for the transaction, then record what it should produce
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos, input bit typed = 1'b0,
			input enc_word_t typed_word = '0);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eos;
		do
			@(posedge clk);
		while (!s_tready);
		encode_step(b, eos);
		if (typed)
			expected_words.insert(expected_words.size(), typed_word);
		else
			foreach (step_words[i])
				expected_words.insert(expected_words.size(), step_words[i]);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	// output side: random back-pressure, off during the calm stretch
	always @(posedge clk)
		m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

	always @(posedge clk) begin
		enc_word_t exp_w;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				$display("%0t unexpected word: expected none actual data %h cnt %0d last %b",
					$time, m_tdata[WORD_W-1:0], m_tdata[WORD_W +: CNT_W], m_tlast);
				errors++;
			end else begin
				exp_w = expected_words.pop_front();
				if (m_tdata[WORD_W-1:0] !== exp_w.data) begin
					$display("%0t data mismatch: expected %h actual %h",
						$time, exp_w.data, m_tdata[WORD_W-1:0]);
					errors++;
				end
				if (m_tdata[WORD_W +: CNT_W] !== exp_w.cnt) begin
					$display("%0t count mismatch: expected %0d actual %0d",
						$time, exp_w.cnt, m_tdata[WORD_W +: CNT_W]);
					errors++;
				end
				if (m_tlast !== exp_w.eos) begin
					$display("%0t last mismatch: expected %b actual %b",
						$time, exp_w.eos, m_tlast);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		enc_word_t         tw;
		logic [BYTE_W-1:0] cur;
		logic [BYTE_W-1:0] rb;
		int                items;
		int                kind;
		int                len;
		logic              eos;

		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tlast     = 1'b0;
		m_tready    = 1'b0;
		errors      = 0;
		calm        = 1'b0;
		idle_cycles = 0;
		seg_len     = 0;
		run_mode    = 1'b0;
		prev_byte   = '0;
		have_prev   = 1'b0;
		cur         = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < N_ROWS; r++) begin
			tw.data = DIR_ROWS[r].word;
			tw.cnt  = DIR_ROWS[r].cnt;
			tw.eos  = 1'b1;
			send_byte(DIR_ROWS[r].data, DIR_ROWS[r].eos, DIR_ROWS[r].typed, tw);
		end

		// hold the input until the back end has caught up
		drain_results();

		// full segments: a run past the cap with no idling on either side,
		// then a full literal plus one byte so that a single byte produces the most words
		calm = 1'b1;
		for (int i = 0; i < CAP + 2; i++)
			send_byte(8'h3C, i == CAP + 1);
		calm = 1'b0;
		for (int i = 0; i <= CAP; i++) begin
			cur = cur ^ BYTE_W'($urandom_range(1, 255));
			send_byte(cur, i == CAP);
		end

		// random streams built from runs and literals, with some noise
		items = 0;
		while (items < RAND_ITEMS) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				cur = BYTE_W'($urandom_range(0, 255));
				send_byte(cur, $urandom_range(0, 2) == 0);
				items++;
			end else begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
				eos = 1'b0;
				if (kind <= 4)
					rb = cur ^ BYTE_W'($urandom_range(1, 255));
				for (int i = 0; i < len; i++) begin
					if (kind <= 4)
						cur = rb;
					else
						cur = cur ^ BYTE_W'($urandom_range(1, 255));
					eos = (i == len - 1) && ($urandom_range(0, 3) == 0);
					send_byte(cur, eos);
					items++;
				end
			end
		end
		calm = 1'b0;

		// close the open stream so every segment leaves the block
		cur = cur ^ BYTE_W'($urandom_range(1, 255));
		send_byte(cur, 1'b1);
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: sim.f
src/bre_pkg.sv
src/bre_lit_ram.sv
src/bre_cmd_fifo.sv
src/bre_front.sv
src/bre_back.sv
src/byte_rle_encoder_unit.sv
tb/sv/tb_byte_rle_encoder_unit.sv
